FILE: hdl/assert_macros.svh
// Assertion macros for the checker file of this project.
// No dependencies; take it in with a plain include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/rslp_pkg.sv
// Types, character codes and helper functions for the status line parser.
// No dependencies; the RTL modules, the checker and the testbench import it.
`timescale 1ns / 1ps

package rslp_pkg;

  typedef logic [7:0] char_t;

  typedef enum logic [2:0] {
    KIND_IGNORED    = 3'd0,
    KIND_VOLUME     = 3'd1,
    KIND_VOLUME_MAX = 3'd2,
    KIND_MUTE       = 3'd3,
    KIND_POWER      = 3'd4,
    KIND_INPUT      = 3'd5
  } kind_t;

  localparam char_t CHAR_CR    = 8'h0D;
  localparam char_t CHAR_LF    = 8'h0A;
  localparam char_t CHAR_SPACE = 8'h20;
  localparam char_t CHAR_TAB   = 8'h09;
  localparam char_t CHAR_VT    = 8'h0B;
  localparam char_t CHAR_FF    = 8'h0C;
  localparam char_t CHAR_ZERO  = 8'h30;
  localparam char_t CHAR_NINE  = 8'h39;
  localparam char_t CHAR_FIVE  = 8'h35;
  localparam char_t CHAR_A     = 8'h41;
  localparam char_t CHAR_I     = 8'h49;
  localparam char_t CHAR_M     = 8'h4D;
  localparam char_t CHAR_N     = 8'h4E;
  localparam char_t CHAR_O     = 8'h4F;
  localparam char_t CHAR_P     = 8'h50;
  localparam char_t CHAR_S     = 8'h53;
  localparam char_t CHAR_U     = 8'h55;
  localparam char_t CHAR_V     = 8'h56;
  localparam char_t CHAR_W     = 8'h57;
  localparam char_t CHAR_X     = 8'h58;
  localparam char_t CHAR_Z     = 8'h5A;

  localparam int HEAD_LEN  = 5;
  localparam int DIGIT_LEN = 3;

  localparam logic [7:0]        HALF_CEIL      = 8'd196;
  localparam logic signed [9:0] DB_OFFSET_HALF = 10'sd160;  // 80 dB in half steps
  localparam logic [7:0]        MAX_RESET      = 8'd196;
  localparam logic signed [7:0] USER_MAX_RESET = 8'sd18;

  // Snapshot of the line being assembled.
  typedef struct packed {
    logic                      len_ge1;
    logic                      len_ge2;
    logic                      len_ge4;
    logic                      len_ge5;
    char_t [HEAD_LEN-1:0]      head;
    char_t [DIGIT_LEN-1:0]     digits;
    logic [1:0]                digit_count;
    char_t [1:0]               tail;      // [1] is the latest kept char
  } line_t;

  typedef struct packed {
    kind_t      message_kind;
    logic [7:0] volume_half;
    logic [7:0] max_half;
    logic [7:0] ceiling_half;
    logic       muted;
    logic       powered;
    logic       have_volume;
    logic       state_changed;
  } result_t;

  function automatic logic is_eol(input char_t c);
    return (c == CHAR_CR) || (c == CHAR_LF);
  endfunction

  function automatic logic is_dig(input char_t c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  function automatic logic is_blank(input char_t c);
    return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_VT) || (c == CHAR_FF);
  endfunction

  // Two decimal digits of whole dB to half steps; low nibble of an ASCII digit is its value.
  function automatic logic [7:0] half_from(input char_t tens, input char_t ones);
    logic [7:0] db;
    db = ({4'b0, tens[3:0]} * 8'd10) + {4'b0, ones[3:0]};
    return {db[6:0], 1'b0};
  endfunction

endpackage

FILE: hdl/rslp_if.sv
// Valid/ready channel interfaces for the status line parser.
// Depends on nothing; the payload widths follow the field list of the block.
`timescale 1ns / 1ps

interface rslp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       volume_pending;

  modport source (output valid, output rx_byte, output volume_pending, input ready);
  modport sink   (input valid, input rx_byte, input volume_pending, output ready);
endinterface

interface rslp_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] message_kind;
  logic [7:0] volume_half;
  logic [7:0] max_half;
  logic [7:0] ceiling_half;
  logic       muted;
  logic       powered;
  logic       have_volume;
  logic       state_changed;

  modport source (output valid, output message_kind, output volume_half, output max_half,
                  output ceiling_half, output muted, output powered, output have_volume,
                  output state_changed, input ready);
  modport sink   (input valid, input message_kind, input volume_half, input max_half,
                  input ceiling_half, input muted, input powered, input have_volume,
                  input state_changed, output ready);
endinterface

FILE: hdl/rslp_line_asm.sv
// Line assembly: keeps length, first five chars, MVMAX digit chars and last two chars.
// Depends on rslp_pkg.
`timescale 1ns / 1ps

module rslp_line_asm #(
  parameter int LINE_MAX = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  rslp_pkg::char_t rx_byte,
  output rslp_pkg::line_t line
);
  import rslp_pkg::*;

  localparam int LCW = $clog2(LINE_MAX + 1);

  logic [LCW-1:0]         line_count;
  char_t [HEAD_LEN-1:0]   head;
  char_t [DIGIT_LEN-1:0]  digits;
  logic [1:0]             digit_count;
  char_t [1:0]            tail;

  logic keep;
  logic to_head;
  logic to_digit;

  assign keep     = !is_eol(rx_byte) && (line_count < LCW'(LINE_MAX));
  assign to_head  = line_count < LCW'(HEAD_LEN);
  assign to_digit = (digit_count < 2'(DIGIT_LEN)) &&
                    !((digit_count == 2'd0) && is_blank(rx_byte));

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count  <= '0;
      digit_count <= '0;
    end else if (accept) begin
      if (is_eol(rx_byte)) begin
        line_count  <= '0;
        digit_count <= '0;
      end else if (keep) begin
        line_count <= line_count + LCW'(1);
        if (!to_head && to_digit) begin
          digit_count <= digit_count + 2'd1;
        end
      end
    end
  end

  // Char storage needs no reset: each slot is qualified by a length or count.
  always_ff @(posedge clk) begin
    if (accept && keep) begin
      if (to_head) begin
        head[line_count[2:0]] <= rx_byte;
      end else if (to_digit) begin
        digits[digit_count] <= rx_byte;
      end
      tail <= {rx_byte, tail[1]};
    end
  end

  always_comb begin
    line.len_ge1     = line_count >= LCW'(1);
    line.len_ge2     = line_count >= LCW'(2);
    line.len_ge4     = line_count >= LCW'(4);
    line.len_ge5     = line_count >= LCW'(5);
    line.head        = head;
    line.digits      = digits;
    line.digit_count = digit_count;
    line.tail        = tail;
  end

endmodule

FILE: hdl/rslp_decoder.sv
// Line decoder and status registers: decodes a finished line and updates status.
// Depends on rslp_pkg.
`timescale 1ns / 1ps

module rslp_decoder (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic signed [7:0] cfg_wdata,
  input  logic              fire,
  input  logic              volume_pending,
  input  rslp_pkg::line_t   line,
  output rslp_pkg::result_t result
);
  import rslp_pkg::*;

  logic signed [7:0] user_max_db;
  logic [7:0]        volume_reg, volume_next;
  logic [7:0]        max_reg, max_next;
  logic              muted_reg, muted_next;
  logic              powered_reg, powered_next;
  logic              have_volume_reg, have_volume_next;
  kind_t             kind;
  logic              changed;

  logic              is_mvmax, is_mv, is_mu, is_pw, is_si, ends_on;
  logic [7:0]        max_half, vol_half;
  logic              max_ok, vol_ok;
  logic signed [9:0] own_ceil, min_ceil;

  assign is_mvmax = line.len_ge5 && line.head[0] == CHAR_M && line.head[1] == CHAR_V &&
                    line.head[2] == CHAR_M && line.head[3] == CHAR_A &&
                    line.head[4] == CHAR_X;
  assign is_mv    = line.head[0] == CHAR_M && line.head[1] == CHAR_V;
  assign is_mu    = line.head[0] == CHAR_M && line.head[1] == CHAR_U;
  assign is_pw    = (line.head[0] == CHAR_Z && line.head[1] == CHAR_M) ||
                    (line.head[0] == CHAR_P && line.head[1] == CHAR_W);
  assign is_si    = line.head[0] == CHAR_S && line.head[1] == CHAR_I;
  assign ends_on  = line.tail[0] == CHAR_O && line.tail[1] == CHAR_N;

  always_comb begin
    max_half = half_from(line.digits[0], line.digits[1]) +
               {7'b0, (line.digit_count == 2'd3) && (line.digits[2] == CHAR_FIVE)};
    max_ok   = (line.digit_count >= 2'd2) && is_dig(line.digits[0]) &&
               is_dig(line.digits[1]) && (max_half != 8'd0) && (max_half <= HALF_CEIL);
    vol_half = half_from(line.head[2], line.head[3]) +
               {7'b0, line.len_ge5 && (line.head[4] == CHAR_FIVE)};
    vol_ok   = line.len_ge4 && is_dig(line.head[2]) && is_dig(line.head[3]);
  end

  always_comb begin
    kind             = KIND_IGNORED;
    changed          = 1'b0;
    volume_next      = volume_reg;
    max_next         = max_reg;
    muted_next       = muted_reg;
    powered_next     = powered_reg;
    have_volume_next = have_volume_reg;
    if (line.len_ge2) begin
      priority if (is_mvmax) begin
        kind = KIND_VOLUME_MAX;
        if (max_ok) begin
          max_next = max_half;
          changed  = 1'b1;
        end
      end else if (is_mv) begin
        kind = KIND_VOLUME;
        if (vol_ok) begin
          if (!volume_pending) begin
            volume_next = vol_half;
          end
          have_volume_next = 1'b1;
          changed          = 1'b1;
        end
      end else if (is_mu) begin
        kind       = KIND_MUTE;
        muted_next = ends_on;
        changed    = 1'b1;
      end else if (is_pw) begin
        kind         = KIND_POWER;
        powered_next = ends_on;
        changed      = 1'b1;
      end else if (is_si) begin
        kind    = KIND_INPUT;
        changed = 1'b1;
      end else begin
        kind = KIND_IGNORED;
      end
    end
  end

  // Ceiling: min of receiver max and (user limit + 80) * 2, clamped to 0..196.
  always_comb begin
    own_ceil = {{2{user_max_db[7]}}, user_max_db} * 10'sd2 + DB_OFFSET_HALF;
    min_ceil = ($signed({2'b0, max_next}) < own_ceil) ? $signed({2'b0, max_next}) : own_ceil;
    result.message_kind  = kind;
    result.volume_half   = volume_next;
    result.max_half      = max_next;
    if (min_ceil < 10'sd0) begin
      result.ceiling_half = 8'd0;
    end else begin
      result.ceiling_half = min_ceil[7:0];
    end
    result.muted         = muted_next;
    result.powered       = powered_next;
    result.have_volume   = have_volume_next;
    result.state_changed = changed;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      user_max_db     <= USER_MAX_RESET;
      volume_reg      <= '0;
      max_reg         <= MAX_RESET;
      muted_reg       <= 1'b0;
      powered_reg     <= 1'b0;
      have_volume_reg <= 1'b0;
    end else begin
      if (cfg_we) begin
        user_max_db <= cfg_wdata;
      end
      if (fire) begin
        volume_reg      <= volume_next;
        max_reg         <= max_next;
        muted_reg       <= muted_next;
        powered_reg     <= powered_next;
        have_volume_reg <= have_volume_next;
      end
    end
  end

endmodule

FILE: hdl/rslp_out_reg.sv
// Result register: holds one decoded beat until the sink takes it.
// Depends on rslp_pkg and rslp_out_if.
`timescale 1ns / 1ps

module rslp_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  rslp_pkg::result_t data,
  output logic              free,
  rslp_out_if.source        out_ch
);
  import rslp_pkg::*;

  logic    valid;
  result_t held;

  // Free when empty or when the held beat leaves this cycle.
  assign free = !valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (free) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      held <= data;
    end
  end

  assign out_ch.valid         = valid;
  assign out_ch.message_kind  = held.message_kind;
  assign out_ch.volume_half   = held.volume_half;
  assign out_ch.max_half      = held.max_half;
  assign out_ch.ceiling_half  = held.ceiling_half;
  assign out_ch.muted         = held.muted;
  assign out_ch.powered       = held.powered;
  assign out_ch.have_volume   = held.have_volume;
  assign out_ch.state_changed = held.state_changed;

endmodule

FILE: hdl/receiver_status_line_parser.sv
// Channel  | Dir | Payload                                          | Beat taken when
// in_ch    | in  | rx_byte, volume_pending                          | valid && ready
// out_ch   | out | message_kind, volume/max/ceiling half, flags     | valid && ready
// cfg      | in  | cfg_wdata -> user_max_db                         | cfg_we
//
// One beat per cycle. A result appears in the cycle after its line end beat.
// Throughput is set by the single result register: in_ch.ready drops only while a
// result is held and out_ch is stalled.
// Reset (rst, synchronous) empties the line, clears status, sets max to 196 and the
// user limit to 18 dB. No clearing pass is needed.
// Depends on rslp_pkg, rslp_if, rslp_line_asm, rslp_decoder, rslp_out_reg.
`timescale 1ns / 1ps

module receiver_status_line_parser #(
  parameter int LINE_MAX = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic signed [7:0] cfg_wdata,
  rslp_in_if.sink           in_ch,
  rslp_out_if.source        out_ch
);
  import rslp_pkg::*;

  logic    accept;
  logic    free;
  logic    fire;
  line_t   line;
  result_t result;

  // Take a beat whenever the result register can hold whatever it produces.
  assign in_ch.ready = free;
  assign accept      = in_ch.valid && free;

  // Decode only on a line end that closes a non-empty line; empty ends and
  // ordinary chars advance the line state and emit nothing.
  assign fire = accept && is_eol(in_ch.rx_byte) && line.len_ge1;

  rslp_line_asm #(
    .LINE_MAX (LINE_MAX)
  ) u_line_asm (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (in_ch.rx_byte),
    .line    (line)
  );

  // Decoder reads the line as it stood before this beat and commits status on fire.
  rslp_decoder u_decoder (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .fire           (fire),
    .volume_pending (in_ch.volume_pending),
    .line           (line),
    .result         (result)
  );

  // Hold the result beat until out_ch takes it.
  rslp_out_reg u_out_reg (
    .clk    (clk),
    .rst    (rst),
    .load   (fire),
    .data   (result),
    .free   (free),
    .out_ch (out_ch)
  );

endmodule

FILE: hdl/rslp_checker.sv
// Port-level checks for the status line parser, bound to the top level.
// Depends on rslp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rslp_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] message_kind,
  input logic [7:0] max_half,
  input logic [7:0] ceiling_half,
  input logic       state_changed
);
  import rslp_pkg::*;

  // Hold a stalled result beat.
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(message_kind), "stalled result changed")
  // Drop any result on reset.
  `ASSERT_NEXT_ALWAYS(a_rst_empty, clk, rst, !out_valid, "result valid after reset")
  // An empty result register never blocks input.
  `ASSERT_IMPL(a_ready_free, clk, rst, !out_valid, in_ready, "input blocked with no result held")
  // Ignored lines never report a change.
  `ASSERT_IMPL(a_ignored_quiet, clk, rst, out_valid && message_kind == KIND_IGNORED, !state_changed, "ignored line marked changed")
  // Ceiling never exceeds the receiver maximum.
  `ASSERT_IMPL(a_ceil_bound, clk, rst, out_valid, ceiling_half <= max_half, "ceiling above receiver maximum")

endmodule

bind receiver_status_line_parser rslp_checker u_rslp_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .message_kind  (out_ch.message_kind),
  .max_half      (out_ch.max_half),
  .ceiling_half  (out_ch.ceiling_half),
  .state_changed (out_ch.state_changed)
);

FILE: dv/testbench.sv
// Self-checking testbench for receiver_status_line_parser: directed status lines, then random
// line traffic under several user limits; reports checked by the predictor or typed rows.
// Depends on rslp_pkg, rslp_if and the parser RTL.
`timescale 1ns / 1ps

module testbench;
  import rslp_pkg::*;

  localparam int KEEP_MAX     = 64;    // characters kept per line
  localparam int DB_OFFSET    = 80;    // user limit offset in dB
  localparam int RANDOM_BEATS = 1224;
  localparam int PHASES       = 6;
  localparam int SETTLE       = 4;     // quiet cycles before a limit write
  localparam int DRAIN        = 8;     // quiet cycles at the end
  localparam int IDLE_LIMIT   = 1000;  // cycles with no beat before giving up

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_we;
  logic signed [7:0] cfg_wdata;

  rslp_in_if  in_ch ();
  rslp_out_if out_ch ();

  receiver_status_line_parser #(
    .LINE_MAX (KEEP_MAX)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor: a software copy of the line buffer and the receiver status.
  // ---------------------------------------------------------------------------
  int                unsigned line_len = 0;
  char_t             head_q [HEAD_LEN]  = '{default: '0};
  char_t             dig_q  [DIGIT_LEN] = '{default: '0};
  int                unsigned dig_n = 0;
  char_t             tail_q [2] = '{default: '0};
  logic [7:0]        vol_q      = '0;
  logic [7:0]        max_q      = MAX_RESET;
  logic              mute_q     = 1'b0;
  logic              power_q    = 1'b0;
  logic              havevol_q  = 1'b0;
  logic signed [7:0] user_db    = USER_MAX_RESET;

  // Reports still owed by the block, oldest first.
  result_t status_due [$];
  int      fails = 0;
  int      idle_cycles = 0;

  // Sender control and the line being built for the random part.
  bit      sender_burst = 1'b0;
  char_t   line_bytes [$];

  typedef struct {
    string   text;
    char_t   eol;
    logic    pend;
    bit      typed;   // use the hand-written report below instead of the predictor
    result_t want;
  } line_row_t;

  line_row_t dir_rows [$];

  function automatic logic dec_digit(input char_t c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  function automatic logic head_matches(input string p);
    if (line_len < p.len()) return 1'b0;
    for (int i = 0; i < p.len(); i++)
      if (head_q[i] != char_t'(p[i])) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic tail_on();
    return (line_len >= 2) && (tail_q[0] == CHAR_O) && (tail_q[1] == CHAR_N);
  endfunction

  // Advance the line buffer by one character; return 1 with the report when a
  // non-empty line ends.
  function automatic logic parse_char(input char_t c, input logic pend, output result_t r);
    kind_t kind;
    logic  changed;
    int    half;
    int    ceil_half;
    r = '0;
    if (c == CHAR_CR || c == CHAR_LF) begin
      if (line_len == 0) begin
        dig_n = 0;
        return 1'b0;
      end
      kind    = KIND_IGNORED;
      changed = 1'b0;
      if (line_len >= 2) begin
        // Longest prefix first: MVMAX would otherwise read as MV.
        if (head_matches("MVMAX")) begin
          kind = KIND_VOLUME_MAX;
          if (dig_n >= 2 && dec_digit(dig_q[0]) && dec_digit(dig_q[1])) begin
            half = (int'(dig_q[0] - CHAR_ZERO) * 10 + int'(dig_q[1] - CHAR_ZERO)) * 2;
            if (dig_n >= 3 && dig_q[2] == CHAR_FIVE) half++;
            if (half > 0 && half <= int'(HALF_CEIL)) begin
              max_q   = 8'(half);
              changed = 1'b1;
            end
          end
        end else if (head_matches("MV")) begin
          kind = KIND_VOLUME;
          if (line_len >= 4 && dec_digit(head_q[2]) && dec_digit(head_q[3])) begin
            half = (int'(head_q[2] - CHAR_ZERO) * 10 + int'(head_q[3] - CHAR_ZERO)) * 2;
            if (line_len >= 5 && head_q[4] == CHAR_FIVE) half++;
            // A local volume waiting to go out wins over the receiver's report.
            if (!pend) vol_q = 8'(half);
            havevol_q = 1'b1;
            changed   = 1'b1;
          end
        end else if (head_matches("MU")) begin
          kind    = KIND_MUTE;
          mute_q  = tail_on();
          changed = 1'b1;
        end else if (head_matches("ZM") || head_matches("PW")) begin
          kind    = KIND_POWER;
          power_q = tail_on();
          changed = 1'b1;
        end else if (head_matches("SI")) begin
          kind    = KIND_INPUT;
          changed = 1'b1;
        end
      end
      // Ceiling: smaller of receiver and user limits, clamped to the legal span.
      ceil_half = (int'(user_db) + DB_OFFSET) * 2;
      if (int'(max_q) < ceil_half) ceil_half = int'(max_q);
      if (ceil_half < 0) ceil_half = 0;
      if (ceil_half > int'(HALF_CEIL)) ceil_half = int'(HALF_CEIL);
      r.message_kind  = kind;
      r.volume_half   = vol_q;
      r.max_half      = max_q;
      r.ceiling_half  = 8'(ceil_half);
      r.muted         = mute_q;
      r.powered       = power_q;
      r.have_volume   = havevol_q;
      r.state_changed = changed;
      line_len = 0;
      dig_n    = 0;
      return 1'b1;
    end
    // Drop characters past the line limit.
    if (line_len < KEEP_MAX) begin
      if (line_len < HEAD_LEN) begin
        head_q[line_len] = c;
      end else if (dig_n < DIGIT_LEN) begin
        // Skip leading blanks only; a blank after a digit is kept.
        if (!(dig_n == 0 && (c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_VT ||
                             c == CHAR_FF))) begin
          dig_q[dig_n] = c;
          dig_n++;
        end
      end
      tail_q[0] = tail_q[1];
      tail_q[1] = c;
      line_len++;
    end
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void add_row(input string text, input char_t eol, input logic pend,
                                  input bit typed = 1'b0, input result_t want = '0);
    line_row_t row;
    row.text  = text;
    row.eol   = eol;
    row.pend  = pend;
    row.typed = typed;
    row.want  = want;
    dir_rows.push_back(row);
  endfunction

  function automatic string z_run(input int n);
    string s;
    s = "";
    repeat (n) s = {s, "Z"};
    return s;
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) line_bytes.push_back(char_t'(s[i]));
  endfunction

  function automatic char_t digit_char();
    return char_t'(CHAR_ZERO + $urandom_range(0, 9));
  endfunction

  function automatic char_t letter_char();
    return char_t'(CHAR_A + $urandom_range(0, 25));
  endfunction

  // Any byte, with the all-zeros and all-ones patterns forced now and then.
  function automatic char_t noise_byte();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return char_t'($urandom_range(0, 255));
  endfunction

  function automatic char_t blank_char();
    case ($urandom_range(0, 3))
      0:       return CHAR_SPACE;
      1:       return CHAR_TAB;
      2:       return CHAR_VT;
      default: return CHAR_FF;
    endcase
  endfunction

  // Build one random line in line_bytes and return its terminator. Mostly
  // well-formed reports with random content; the rest is noise, empty,
  // one-character and overlong lines.
  function automatic char_t build_line();
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    line_bytes.delete();
    if (pick < 22) begin
      push_text("MV");
      line_bytes.push_back($urandom_range(0, 9) == 0 ? noise_byte() : digit_char());
      line_bytes.push_back(digit_char());
      n = $urandom_range(0, 9);
      if (n < 5) line_bytes.push_back(CHAR_FIVE);
      else if (n < 7) line_bytes.push_back(noise_byte());
    end else if (pick < 40) begin
      push_text("MVMAX");
      repeat ($urandom_range(0, 3)) line_bytes.push_back(blank_char());
      line_bytes.push_back(digit_char());
      line_bytes.push_back($urandom_range(0, 9) == 0 ? blank_char() : digit_char());
      n = $urandom_range(0, 9);
      if (n < 4) line_bytes.push_back(CHAR_FIVE);
      else if (n < 6) line_bytes.push_back(CHAR_ZERO);
      else if (n == 9) line_bytes.push_back(noise_byte());
    end else if (pick < 55) begin
      case ($urandom_range(0, 2))
        0:       push_text("MU");
        1:       push_text("ZM");
        default: push_text("PW");
      endcase
      n = $urandom_range(0, 9);
      if (n < 4) push_text("ON");
      else if (n < 7) push_text("OFF");
      else repeat ($urandom_range(1, 3)) line_bytes.push_back(noise_byte());
    end else if (pick < 70) begin
      push_text("SI");
      repeat ($urandom_range(0, 6)) line_bytes.push_back(letter_char());
    end else if (pick < 72) begin
      // Overlong: the trailing ON may or may not fall inside the kept part.
      push_text($urandom_range(0, 1) ? "MU" : "PW");
      repeat ($urandom_range(55, 70)) line_bytes.push_back(letter_char());
      push_text("ON");
    end else if (pick < 77) begin
      // Empty line: terminator only.
    end else if (pick < 82) begin
      line_bytes.push_back($urandom_range(0, 1) ? CHAR_M : noise_byte());
    end else begin
      repeat ($urandom_range(1, 10)) line_bytes.push_back(noise_byte());
    end
    return $urandom_range(0, 1) ? CHAR_CR : CHAR_LF;
  endfunction

  // Drive one input beat after a random gap (none in a burst) and hold it until accepted; queue
  // the report that the beat completes, if any.
  task automatic send_beat(input char_t c, input logic pend, input bit typed,
                           input result_t want);
    int      gap;
    result_t r;
    gap = sender_burst ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.rx_byte        <= c;
    in_ch.volume_pending <= pend;
    do @(posedge clk); while (!in_ch.ready);
    if (parse_char(c, pend, r)) status_due.push_back(typed ? want : r);
  endtask

  // Write the user limit with the block idle: drop valid, drain all reports,
  // let the last line end settle, then write.
  task automatic set_user_limit(input logic signed [7:0] v);
    in_ch.valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    user_db    = v;
  endtask

  // ---------------------------------------------------------------------------
  // Main stimulus
  // ---------------------------------------------------------------------------
  initial begin
    result_t           idle_rpt;
    result_t           rpt;
    int                sent;
    char_t             eol;
    logic signed [7:0] limit_v;

    rst                  = 1'b1;
    cfg_we               = 1'b0;
    cfg_wdata            = '0;
    in_ch.valid          = 1'b0;
    in_ch.rx_byte        = '0;
    in_ch.volume_pending = 1'b0;

    // Status straight after reset, for lines that change nothing.
    idle_rpt = '{KIND_IGNORED, 8'd0, 8'd196, 8'd196, 1'b0, 1'b0, 1'b0, 1'b0};

    add_row("", CHAR_CR, 1'b0);                        // empty line: no report
    add_row("M", CHAR_LF, 1'b0, 1'b1, idle_rpt);        // too short to decode
    add_row("XY", CHAR_CR, 1'b0, 1'b1, idle_rpt);       // unknown prefix
    rpt = '{KIND_VOLUME, 8'd0, 8'd196, 8'd196, 1'b0, 1'b0, 1'b1, 1'b1};
    add_row("MV00", CHAR_CR, 1'b0, 1'b1, rpt);          // lowest volume
    rpt = '{KIND_VOLUME, 8'd199, 8'd196, 8'd196, 1'b0, 1'b0, 1'b1, 1'b1};
    add_row("MV995", CHAR_LF, 1'b0, 1'b1, rpt);         // highest volume, half step
    rpt = '{KIND_VOLUME_MAX, 8'd199, 8'd196, 8'd196, 1'b0, 1'b0, 1'b1, 1'b0};
    add_row("MVMAX 985", CHAR_CR, 1'b0, 1'b1, rpt);     // one past the ceiling: rejected
    add_row("MV50", CHAR_CR, 1'b1);                     // local volume pending
    add_row("MVx1", CHAR_LF, 1'b0);                     // bad volume digit
    add_row("MV5", CHAR_CR, 1'b0);                      // volume with one digit
    add_row("MVMAX98", CHAR_CR, 1'b0);                  // ceiling exactly
    add_row("MVMAX\t\v\f 005", CHAR_LF, 1'b0);          // all blanks, one half step
    add_row("MVMAX00", CHAR_CR, 1'b0);                  // zero maximum: rejected
    add_row("MVMAX 50", CHAR_LF, 1'b0);
    add_row("MVMAX", CHAR_CR, 1'b0);                    // no digits at all
    add_row("MUON", CHAR_CR, 1'b0);
    add_row("MUOFF", CHAR_LF, 1'b0);
    add_row("ZMON", CHAR_CR, 1'b0);
    add_row("PWOFF", CHAR_CR, 1'b0);
    add_row("PWON", CHAR_LF, 1'b0);
    add_row("SICD", CHAR_CR, 1'b0);
    add_row("MU", CHAR_CR, 1'b0);                       // mute with nothing after it
    add_row("ON", CHAR_LF, 1'b0);
    add_row("\377\200", CHAR_CR, 1'b0);                 // high-bit bytes
    add_row({"MU", z_run(60), "ON"}, CHAR_CR, 1'b0);        // exactly the line limit
    add_row({"MU", z_run(60), "ONXX"}, CHAR_LF, 1'b0);      // overflow past ON: dropped
    add_row({"MU", z_run(62), "ON"}, CHAR_CR, 1'b0);        // ON falls past the limit

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed lines under the reset user limit.
    foreach (dir_rows[k]) begin
      sender_burst = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < dir_rows[k].text.len(); i++)
        send_beat(dir_rows[k].text[i], 1'($urandom_range(0, 1)), 1'b0, '0);
      send_beat(dir_rows[k].eol, dir_rows[k].pend, dir_rows[k].typed, dir_rows[k].want);
    end

    // Random lines, one user limit per phase; extremes and out-of-range
    // values exercise both ends of the ceiling clamp.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       limit_v = -8'sd80;
        1:       limit_v = 8'sd127;
        2:       limit_v = 8'sd0;
        3:       limit_v = -8'sd128;
        4:       limit_v = 8'sd18;
        default: limit_v = 8'($urandom_range(0, 98)) - 8'sd80;
      endcase
      set_user_limit(limit_v);
      sent = 0;
      while (sent < RANDOM_BEATS / PHASES) begin
        eol          = build_line();
        sender_burst = ($urandom_range(0, 3) == 0);
        foreach (line_bytes[i]) send_beat(line_bytes[i], 1'($urandom_range(0, 1)), 1'b0, '0);
        send_beat(eol, $urandom_range(0, 9) < 7 ? 1'b0 : 1'b1, 1'b0, '0);
        sent += line_bytes.size() + 1;
      end
    end

    // Drop valid, drain the owed reports, then give the block a few more
    // cycles to show any stray beat.
    in_ch.valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Report sink: random stalls with bursts of back-to-back acceptance.
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  initial begin
    int      stall;
    int      burst_left;
    result_t want;
    burst_left   = 0;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (burst_left > 0) begin
        stall = 0;
        burst_left--;
      end else if ($urandom_range(0, 9) == 0) begin
        stall      = 0;
        burst_left = $urandom_range(5, 30);
      end else begin
        stall = $urandom_range(0, 17);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      // Beat taken at this edge; the fields still hold their pre-edge values.
      if (status_due.size() == 0) begin
        $error("report with none owed: message_kind %0d", out_ch.message_kind);
        fails++;
      end else begin
        want = status_due.pop_front();
        check_field("message_kind", int'(want.message_kind), int'(out_ch.message_kind));
        check_field("volume_half", want.volume_half, out_ch.volume_half);
        check_field("max_half", want.max_half, out_ch.max_half);
        check_field("ceiling_half", want.ceiling_half, out_ch.ceiling_half);
        check_field("muted", want.muted, out_ch.muted);
        check_field("powered", want.powered, out_ch.powered);
        check_field("have_volume", want.have_volume, out_ch.have_volume);
        check_field("state_changed", want.state_changed, out_ch.state_changed);
      end
    end
  end

  // Watchdog: end the run when no beat moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
